### rtl/argon2_reference_index_map_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Argon2 reference index map
// Shared concurrent assertion forms used by the checker of the core.
// ----------------------------------------------------------------------------
`ifndef ARGON2_REFERENCE_INDEX_MAP_CORE_DEFINES_SVH
`define ARGON2_REFERENCE_INDEX_MAP_CORE_DEFINES_SVH

// A condition that holds at every edge outside reset.
`define ARI_ASSERT_HOLD(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error(msg);

// A trigger that forces a condition at the next edge, reset included.
`define ARI_ASSERT_NEXT(label, clk, trig, cond, msg) \
    label: assert property (@(posedge clk) (trig) |=> (cond)) else $error(msg);

// A trigger that forces a condition at the next edge, outside reset.
`define ARI_ASSERT_NEXT_RST(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cond)) \
        else $error(msg);

`endif

### rtl/ari_pkg.sv
// ----------------------------------------------------------------------------
// ari_pkg
// Widths, register codes and transfer types of the reference index map.
// ----------------------------------------------------------------------------
`default_nettype none

package ari_pkg;

    localparam int WORD_W    = 64;
    localparam int HALF_W    = 32;
    localparam int LANE_W    = 24;
    localparam int SEG_W     = 23;
    localparam int COL_W     = 24;
    localparam int SLICE_W   = 2;
    // Holds four times the segment length.
    localparam int AREA_W    = SEG_W + 2;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_LANE_COUNT     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_LENGTH = 1'b1;

    localparam logic [LANE_W-1:0] LANE_COUNT_RESET = 24'd1;
    localparam logic [SEG_W-1:0]  SEG_LENGTH_RESET = 23'd2;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

    // Effective configuration, zero values already replaced by one.
    typedef struct packed {
        logic [LANE_W-1:0] lanes;
        logic [SEG_W-1:0]  seg;
    } t_cfg;

    // Classified item handed from the front to the back.
    typedef struct packed {
        logic [HALF_W-1:0] j1;
        logic [LANE_W-1:0] rlane;
        logic [AREA_W-1:0] size;
        logic [AREA_W-1:0] start;
        logic              empty_area;
    } t_mid;

    typedef struct packed {
        logic [LANE_W-1:0] ref_lane;
        logic [COL_W-1:0]  ref_column;
        logic              empty_area;
    } t_res;

endpackage

`default_nettype wire

### rtl/ari_queue.sv
// ----------------------------------------------------------------------------
// ari_queue
// Small first-in first-out queue in flip-flops with push/full, pop/empty.
// ----------------------------------------------------------------------------
`default_nettype none

module ari_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= CNT_W'(r_count + 1'b1);
            end else if (do_pop && !do_push) begin
                r_count <= CNT_W'(r_count - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

### rtl/ari_front.sv
// ----------------------------------------------------------------------------
// ari_front
// Accepts items, reduces J2 and the column by pipelined remainder stages and
// classifies the reference area.
// ----------------------------------------------------------------------------
`default_nettype none

module ari_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire ari_pkg::t_cfg                i_cfg,
    input  wire logic                         i_push,
    output logic                              o_full,
    input  wire logic [ari_pkg::WORD_W-1:0]   i_rand_word,
    input  wire logic                         i_first_pass,
    input  wire logic [ari_pkg::SLICE_W-1:0]  i_slice,
    input  wire logic [ari_pkg::LANE_W-1:0]   i_lane,
    input  wire logic [ari_pkg::COL_W-1:0]    i_column,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output ari_pkg::t_mid                     o_entry
);

    import ari_pkg::*;

    // One quotient bit per stage over the 32-bit J2.
    localparam int DIV_STEPS = HALF_W;

    typedef struct packed {
        logic [HALF_W-1:0] j2;
        logic [HALF_W-1:0] cq;
        logic [LANE_W-1:0] rem_l;
        logic [SEG_W-1:0]  rem_c;
        logic [HALF_W-1:0] j1;
        logic              first;
        logic [SLICE_W-1:0] slice;
        logic [LANE_W-1:0] lane;
    } t_div;

    logic [DIV_STEPS:0] r_vld;
    t_div               r_st [DIV_STEPS+1];
    logic               r_cls_vld;
    t_mid               r_cls;
    t_div               n_st0;
    t_mid               n_cls;
    t_div               last;
    logic               advance;
    logic               forced;
    logic               same;
    logic [LANE_W-1:0]  rlane;
    logic [AREA_W-1:0]  idx;
    logic [AREA_W-1:0]  base;
    logic [AREA_W-1:0]  size_p1;

    function automatic t_div div_step(input t_div s, input t_cfg c);
        logic [LANE_W:0] tl;
        logic [SEG_W:0]  tc;
        t_div            o;
        o  = s;
        tl = {s.rem_l, s.j2[HALF_W-1]};
        if (tl >= {1'b0, c.lanes}) begin
            tl = tl - {1'b0, c.lanes};
        end
        tc = {s.rem_c, s.cq[HALF_W-1]};
        if (tc >= {1'b0, c.seg}) begin
            tc = tc - {1'b0, c.seg};
        end
        o.rem_l = tl[LANE_W-1:0];
        o.rem_c = tc[SEG_W-1:0];
        o.j2    = {s.j2[HALF_W-2:0], 1'b0};
        o.cq    = {s.cq[HALF_W-2:0], 1'b0};
        return o;
    endfunction

    function automatic logic [AREA_W-1:0] seg_times(
        input logic [SLICE_W-1:0] k,
        input logic [SEG_W-1:0]   seg
    );
        logic [AREA_W-1:0] s1;
        logic [AREA_W-1:0] res;
        s1 = AREA_W'(seg);
        unique case (k)
            2'd0: res = '0;
            2'd1: res = s1;
            2'd2: res = s1 << 1;
            2'd3: res = (s1 << 1) + s1;
        endcase
        return res;
    endfunction

    assign advance = !r_cls_vld || i_ready;
    assign o_full  = !advance;
    assign o_valid = r_cls_vld;
    assign o_entry = r_cls;

    always_comb begin
        n_st0.j2    = i_rand_word[WORD_W-1:HALF_W];
        n_st0.cq    = HALF_W'(i_column);
        n_st0.rem_l = '0;
        n_st0.rem_c = '0;
        n_st0.j1    = i_rand_word[HALF_W-1:0];
        n_st0.first = i_first_pass;
        n_st0.slice = i_slice;
        n_st0.lane  = i_lane;
    end

    // The first slice of the first pass always refers to its own lane.
    always_comb begin
        last    = r_st[DIV_STEPS];
        forced  = last.first && (last.slice == '0);
        rlane   = forced ? last.lane : last.rem_l;
        same    = (rlane == last.lane);
        idx     = AREA_W'(last.rem_c);
        base    = last.first ? seg_times(last.slice, i_cfg.seg) : seg_times(2'd3, i_cfg.seg);
        size_p1 = same ? AREA_W'(base + idx) : AREA_W'(base + AREA_W'(idx != '0));
        n_cls.j1         = last.j1;
        n_cls.rlane      = rlane;
        n_cls.size       = AREA_W'(size_p1 - 1'b1);
        n_cls.start      = last.first ? '0
                                      : seg_times(SLICE_W'(last.slice + 1'b1), i_cfg.seg);
        n_cls.empty_area = (size_p1 <= AREA_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_cls_vld <= 1'b0;
        end else if (advance) begin
            r_vld     <= {r_vld[DIV_STEPS-1:0], i_push};
            r_cls_vld <= r_vld[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_st[0] <= n_st0;
            for (int k = 1; k <= DIV_STEPS; k++) begin
                r_st[k] <= div_step(r_st[k-1], i_cfg);
            end
            r_cls <= n_cls;
        end
    end

endmodule

`default_nettype wire

### rtl/ari_back.sv
// ----------------------------------------------------------------------------
// ari_back
// Squares J1, scales it into the reference area and wraps the column.
// ----------------------------------------------------------------------------
`default_nettype none

module ari_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire ari_pkg::t_cfg i_cfg,
    input  wire logic          i_valid,
    output logic               o_take,
    input  wire ari_pkg::t_mid i_entry,
    output logic               o_valid,
    input  wire logic          i_ready,
    output ari_pkg::t_res      o_res
);

    import ari_pkg::*;

    localparam int BACK_STAGES = 4;

    typedef struct packed {
        logic [HALF_W-1:0] x;
        logic [AREA_W-1:0] size;
        logic [AREA_W-1:0] start;
        logic [LANE_W-1:0] rlane;
        logic              empty_area;
    } t_b1;

    typedef struct packed {
        logic [AREA_W-1:0] ph;
        logic [AREA_W-1:0] size;
        logic [AREA_W-1:0] start;
        logic [LANE_W-1:0] rlane;
        logic              empty_area;
    } t_b2;

    typedef struct packed {
        logic [AREA_W:0]   sum;
        logic [LANE_W-1:0] rlane;
        logic              empty_area;
    } t_b3;

    logic [BACK_STAGES-1:0]      r_vld;
    t_b1                         r_b1;
    t_b2                         r_b2;
    t_b3                         r_b3;
    t_res                        r_res;
    logic                        advance;
    logic [2*HALF_W-1:0]         sq;
    logic [AREA_W+HALF_W-1:0]    scaled;
    logic [AREA_W:0]             lane_len;
    logic [AREA_W:0]             wrapped;

    assign advance = !r_vld[BACK_STAGES-1] || i_ready;
    assign o_take  = i_valid && advance;
    assign o_valid = r_vld[BACK_STAGES-1];
    assign o_res   = r_res;

    assign sq       = (2*HALF_W)'(i_entry.j1) * (2*HALF_W)'(i_entry.j1);
    assign scaled   = (AREA_W+HALF_W)'(r_b1.size) * (AREA_W+HALF_W)'(r_b1.x);
    assign lane_len = {1'b0, i_cfg.seg, 2'b00};
    // start + rel stays below twice the lane length, so one subtraction wraps it.
    assign wrapped  = (r_b3.sum >= lane_len) ? (r_b3.sum - lane_len) : r_b3.sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (advance) begin
            r_vld <= {r_vld[BACK_STAGES-2:0], o_take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_b1.x          <= sq[2*HALF_W-1:HALF_W];
            r_b1.size       <= i_entry.size;
            r_b1.start      <= i_entry.start;
            r_b1.rlane      <= i_entry.rlane;
            r_b1.empty_area <= i_entry.empty_area;

            r_b2.ph         <= scaled[AREA_W+HALF_W-1:HALF_W];
            r_b2.size       <= r_b1.size;
            r_b2.start      <= r_b1.start;
            r_b2.rlane      <= r_b1.rlane;
            r_b2.empty_area <= r_b1.empty_area;

            r_b3.sum        <= {1'b0, r_b2.start} + {1'b0, r_b2.size}
                             - {1'b0, r_b2.ph} - (AREA_W+1)'(1);
            r_b3.rlane      <= r_b2.rlane;
            r_b3.empty_area <= r_b2.empty_area;

            r_res.ref_lane   <= r_b3.empty_area ? '0 : r_b3.rlane;
            r_res.ref_column <= r_b3.empty_area ? '0 : wrapped[COL_W-1:0];
            r_res.empty_area <= r_b3.empty_area;
        end
    end

endmodule

`default_nettype wire

### rtl/argon2_reference_index_map_core.sv
// ----------------------------------------------------------------------------
// argon2_reference_index_map_core
// Maps a pseudo-random word and a block position to the reference block.
// ----------------------------------------------------------------------------
// The core takes one item per clock cycle while full is low and delivers one
// result per item, in order. On its way to the output ports an item passes
// the 32-stage remainder pipeline that reduces J2 by the lane count (one
// quotient bit per stage, with the column reduced by the segment length
// alongside it), a classification stage, the queue between front and back,
// the four back stages holding the two registered multipliers and the final
// wrap, and the output queue in front of the result ports. The sustained
// rate is one transfer per cycle on both sides when neither side stalls.
// Input transfers use push/full and result transfers use pop/empty, like a
// queue. The configuration registers (lane count, segment length) are
// written through a plain write port and must only change while no item is
// in flight.
`default_nettype none

module argon2_reference_index_map_core #(
    parameter int MID_QUEUE_DEPTH = ari_pkg::MID_DEPTH,
    parameter int OUT_QUEUE_DEPTH = ari_pkg::OUT_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [ari_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ari_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [ari_pkg::WORD_W-1:0]     i_rand_word,
    input  wire logic                           i_first_pass,
    input  wire logic [ari_pkg::SLICE_W-1:0]    i_slice,
    input  wire logic [ari_pkg::LANE_W-1:0]     i_lane,
    input  wire logic [ari_pkg::COL_W-1:0]      i_column,
    output logic                                empty,
    input  wire logic                           pop,
    output logic [ari_pkg::LANE_W-1:0]          o_ref_lane,
    output logic [ari_pkg::COL_W-1:0]           o_ref_column,
    output logic                                o_empty_area
);

    import ari_pkg::*;

    logic [LANE_W-1:0] r_lane_count;
    logic [SEG_W-1:0]  r_segment_length;
    t_cfg              cfg;

    // Front to middle queue.
    logic              front_valid;
    logic              mid_full;
    t_mid              front_entry;

    // Middle queue to back.
    logic              mid_empty;
    logic              back_take;
    t_mid              mid_entry;

    // Back to output queue.
    logic              back_valid;
    logic              out_full;
    t_res              back_res;
    t_res              out_res;

    // Register writes; indices beyond the list are ignored by construction
    // as the index covers exactly the two registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane_count     <= LANE_COUNT_RESET;
            r_segment_length <= SEG_LENGTH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LANE_COUNT:     r_lane_count     <= i_cfg_data[LANE_W-1:0];
                CFG_SEGMENT_LENGTH: r_segment_length <= i_cfg_data[SEG_W-1:0];
            endcase
        end
    end

    // A zero lane count or segment length behaves as one.
    always_comb begin
        cfg.lanes = (r_lane_count == '0) ? LANE_W'(1) : r_lane_count;
        cfg.seg   = (r_segment_length == '0) ? SEG_W'(1) : r_segment_length;
    end

    ari_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_push       (push),
        .o_full       (full),
        .i_rand_word  (i_rand_word),
        .i_first_pass (i_first_pass),
        .i_slice      (i_slice),
        .i_lane       (i_lane),
        .i_column     (i_column),
        .o_valid      (front_valid),
        .i_ready      (!mid_full),
        .o_entry      (front_entry)
    );

    ari_queue #(
        .WIDTH ($bits(t_mid)),
        .DEPTH (MID_QUEUE_DEPTH)
    ) u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_entry),
        .o_full  (mid_full),
        .i_pop   (back_take),
        .o_data  (mid_entry),
        .o_empty (mid_empty)
    );

    ari_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (!mid_empty),
        .o_take  (back_take),
        .i_entry (mid_entry),
        .o_valid (back_valid),
        .i_ready (!out_full),
        .o_res   (back_res)
    );

    // The output queue lets the back keep going while a result waits.
    ari_queue #(
        .WIDTH ($bits(t_res)),
        .DEPTH (OUT_QUEUE_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_valid),
        .i_data  (back_res),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_res),
        .o_empty (empty)
    );

    assign o_ref_lane   = out_res.ref_lane;
    assign o_ref_column = out_res.ref_column;
    assign o_empty_area = out_res.empty_area;

endmodule

`default_nettype wire

### rtl/ari_checker.sv
// ----------------------------------------------------------------------------
// ari_checker
// Port-level assertions for the reference index map core, bound to it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "argon2_reference_index_map_core_defines.svh"

module ari_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        full,
    input wire logic                        empty,
    input wire logic                        pop,
    input wire logic [ari_pkg::LANE_W-1:0]  o_ref_lane,
    input wire logic [ari_pkg::COL_W-1:0]   o_ref_column,
    input wire logic                        o_empty_area
);

    import ari_pkg::*;

    // Reset leaves no result waiting and room for input.
    `ARI_ASSERT_NEXT(a_reset_idle, i_clk, !i_rst_n, empty && !full, "not idle after reset")

    // A waiting result stays until it is taken.
    `ARI_ASSERT_NEXT_RST(a_result_holds, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_ref_lane) && $stable(o_ref_column) && $stable(o_empty_area), "result changed while waiting")

    // An empty reference area carries a zero lane and column.
    `ARI_ASSERT_HOLD(a_empty_area_zero, i_clk, i_rst_n, empty || !o_empty_area || (o_ref_lane == '0 && o_ref_column == '0), "empty area result not zero")

endmodule

bind argon2_reference_index_map_core ari_checker u_checker (.*);

`default_nettype wire
